>>> hw/rtl/biquad_iir_section_top_assert.svh
// ----------------------------------------------------------------------------
// Biquad section assertion macros
// Shared forms for the concurrent checks on the biquad section ports.
// Both sample on the rising clock edge and stay quiet while reset is held.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_SECTION_TOP_ASSERT_SVH
`define BIQUAD_IIR_SECTION_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define BQS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad section check failed");

// Consequent checked in the cycle after the antecedent
`define BQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad section check failed");

`endif

>>> hw/rtl/bqs_pkg.sv
// ----------------------------------------------------------------------------
// Biquad section package
// Fixed widths, register indexes, multiply step codes and the control
// bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package bqs_pkg;

  // Coefficient width (signed, fixed by the register map)
  localparam int COEF_BITS = 24;
  localparam int REG_IDX_BITS = 3;

  // Configuration register indexes
  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_BYPASS = 3'd0,
    REG_B0     = 3'd1,
    REG_B1     = 3'd2,
    REG_B2     = 3'd3,
    REG_A1     = 3'd4,
    REG_A2     = 3'd5
  } reg_idx_t;

  // Multiply steps, issued in this order
  typedef enum logic [2:0] {
    OP_B0 = 3'd0,
    OP_B1 = 3'd1,
    OP_B2 = 3'd2,
    OP_A1 = 3'd3,
    OP_A2 = 3'd4
  } op_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic accept;  // input beat taken this cycle
    logic issue;   // start a product this cycle
    op_t  op;      // which product
    logic load;    // write the output register this cycle
    logic pass;    // current item is a bypass item
  } bqs_ctrl_t;

endpackage

>>> hw/rtl/bqs_mul.sv
// ----------------------------------------------------------------------------
// Biquad section multiplier
// Shared coefficient by sample multiplier with round-half-up to the
// sample grid. One product per cycle, result registered with its step tag.
// ----------------------------------------------------------------------------
module bqs_mul import bqs_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  logic                                                 issue,
  input  op_t                                                  op,
  input  logic signed [COEF_BITS-1:0]                          coef,
  input  logic signed [SAMPLE_BITS-1:0]                        val,
  output logic                                                 rnd_vld,
  output op_t                                                  rnd_op,
  output logic signed [COEF_BITS+SAMPLE_BITS-COEF_FRAC_BITS-1:0] rnd
);

  localparam int PW = COEF_BITS + SAMPLE_BITS;
  localparam int RW = PW - COEF_FRAC_BITS;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (COEF_FRAC_BITS - 1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] biased;
  logic signed [PW-1:0] shifted;
  logic signed [RW-1:0] rnd_nxt;
  logic signed [RW-1:0] rnd_r;
  logic                 vld_r;
  op_t                  op_r;

  // Multiply, add half an LSB, drop the fraction bits
  always_comb begin
    prod    = coef * val;
    biased  = prod + HALF;
    shifted = biased >>> COEF_FRAC_BITS;
    rnd_nxt = shifted[RW-1:0];
  end

  // Hold the rounded product and its tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rnd_r <= rnd_nxt;
      op_r  <= op;
    end
  end

  assign rnd_vld = vld_r;
  assign rnd_op  = op_r;
  assign rnd     = rnd_r;

endmodule

>>> hw/rtl/bqs_seq.sv
// ----------------------------------------------------------------------------
// Biquad section sequencer
// Takes one input beat; for a filtered beat, steps the shared multiplier
// through the five products, lets the last settle; then hands off the result.
// ----------------------------------------------------------------------------
module bqs_seq import bqs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      bypass,
  input  logic      out_free,
  output bqs_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   pass_r, pass_nxt;
  logic   accept;
  logic   load;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign load     = (state_r == ST_DONE) && out_free;

  // Advance through the product steps
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    pass_nxt  = pass_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          pass_nxt  = bypass;
          op_nxt    = OP_B0;
          state_nxt = bypass ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        if (op_r == OP_A2) begin
          state_nxt = ST_WAIT;
        end else begin
          op_nxt = op_t'(op_r + 3'd1);
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_B0;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pass_r  <= pass_nxt;
    end
  end

  // Drive the datapath controls
  always_comb begin
    ctrl.accept = accept;
    ctrl.issue  = (state_r == ST_RUN);
    ctrl.op     = op_r;
    ctrl.load   = load;
    ctrl.pass   = pass_r;
  end

endmodule

>>> hw/rtl/biquad_iir_section_top.sv
// ----------------------------------------------------------------------------
// Biquad IIR section, transposed direct form II
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_stall   in_sample_in
//   out_     out  out_valid / out_stall out_sample_out, out_clipped
//   cfg_     in   cfg_wr_en             cfg_index, cfg_wdata
//
// A filtered sample goes from input beat to the next free input slot through
// five products on the one shared multiplier, a step for the last product to
// accumulate and one to write the output register. A bypass sample goes
// straight from its input beat to the output register write.
// Reset clears both delay values and loads the coefficient reset values.
// A stalled output holds the sequencer in its final step; no new input beat
// is taken until the result has moved into the output register.
// ----------------------------------------------------------------------------
module biquad_iir_section_top import bqs_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20,
  parameter int STATE_BITS     = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  output logic                          out_clipped,
  input  logic                          cfg_wr_en,
  input  logic [REG_IDX_BITS-1:0]       cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_wdata
);

  localparam int PW = COEF_BITS + SAMPLE_BITS;
  localparam int RW = PW - COEF_FRAC_BITS;
  localparam int AW = ((RW > STATE_BITS) ? RW : STATE_BITS) + 2;

  localparam logic signed [AW-1:0] Y_MAX =
    {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] Y_MIN =
    {{(AW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [AW-1:0] D_MAX =
    {{(AW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] D_MIN =
    {{(AW-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0] B0_RESET = COEF_BITS'(64'd1 << COEF_FRAC_BITS);

  // Configuration registers
  logic                        bypass_r;
  logic signed [COEF_BITS-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  // Filter state and working registers
  logic signed [STATE_BITS-1:0]  d1_r, d2_r, d1_nxt, d2_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r, y_nxt;
  logic                          clip_r, clip_nxt;
  logic signed [AW-1:0]          acc1_r, acc2_r;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_clipped_r;

  // Sequencer and multiplier links
  bqs_ctrl_t                     ctrl;
  logic                          out_free;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_val;
  logic                          rnd_vld;
  op_t                           rnd_op;
  logic signed [RW-1:0]          rnd;
  logic signed [AW-1:0]          rnd_ext;
  logic signed [AW-1:0]          y_sum;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b1;
      b0_r     <= B0_RESET;
      b1_r     <= '0;
      b2_r     <= '0;
      a1_r     <= '0;
      a2_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_BYPASS: bypass_r <= cfg_wdata[0];
        REG_B0:     b0_r     <= cfg_wdata;
        REG_B1:     b1_r     <= cfg_wdata;
        REG_B2:     b2_r     <= cfg_wdata;
        REG_A1:     a1_r     <= cfg_wdata;
        REG_A2:     a2_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  bqs_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .bypass   (bypass_r),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Select multiplier operands for the current step
  always_comb begin
    mul_val = (ctrl.op == OP_A1 || ctrl.op == OP_A2) ? y_r : x_r;
    case (ctrl.op)
      OP_B0:   mul_coef = b0_r;
      OP_B1:   mul_coef = b1_r;
      OP_B2:   mul_coef = b2_r;
      OP_A1:   mul_coef = a1_r;
      OP_A2:   mul_coef = a2_r;
      default: mul_coef = '0;
    endcase
  end

  bqs_mul #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (ctrl.issue),
    .op      (ctrl.op),
    .coef    (mul_coef),
    .val     (mul_val),
    .rnd_vld (rnd_vld),
    .rnd_op  (rnd_op),
    .rnd     (rnd)
  );

  // Output sample: add first delay, saturate to the sample width
  always_comb begin
    rnd_ext  = AW'(rnd);
    y_sum    = rnd_ext + AW'(d1_r);
    clip_nxt = (y_sum > Y_MAX) || (y_sum < Y_MIN);
    if (y_sum > Y_MAX) begin
      y_nxt = Y_MAX[SAMPLE_BITS-1:0];
    end else if (y_sum < Y_MIN) begin
      y_nxt = Y_MIN[SAMPLE_BITS-1:0];
    end else begin
      y_nxt = y_sum[SAMPLE_BITS-1:0];
    end
  end

  // Capture the sample and accumulate each rounded product
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      x_r <= in_sample_in;
    end
    if (rnd_vld) begin
      case (rnd_op)
        OP_B0: begin
          y_r    <= y_nxt;
          clip_r <= clip_nxt;
        end
        OP_B1:   acc1_r <= rnd_ext + AW'(d2_r);
        OP_B2:   acc2_r <= rnd_ext;
        OP_A1:   acc1_r <= acc1_r - rnd_ext;
        OP_A2:   acc2_r <= acc2_r - rnd_ext;
        default: ;
      endcase
    end
  end

  // Saturate new delay values to the state width
  always_comb begin
    if (acc1_r > D_MAX) begin
      d1_nxt = D_MAX[STATE_BITS-1:0];
    end else if (acc1_r < D_MIN) begin
      d1_nxt = D_MIN[STATE_BITS-1:0];
    end else begin
      d1_nxt = acc1_r[STATE_BITS-1:0];
    end
    if (acc2_r > D_MAX) begin
      d2_nxt = D_MAX[STATE_BITS-1:0];
    end else if (acc2_r < D_MIN) begin
      d2_nxt = D_MIN[STATE_BITS-1:0];
    end else begin
      d2_nxt = acc2_r[STATE_BITS-1:0];
    end
  end

  // Commit state when a filtered result leaves; bypass leaves it alone
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else if (ctrl.load && !ctrl.pass) begin
      d1_r <= d1_nxt;
      d2_r <= d2_nxt;
    end
  end

  // Output register: load on hand-off, drop once the beat is taken
  assign out_valid_nxt = ctrl.load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      out_sample_r  <= ctrl.pass ? x_r : y_r;
      out_clipped_r <= ctrl.pass ? 1'b0 : clip_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

>>> hw/rtl/bqs_checker.sv
// ----------------------------------------------------------------------------
// Biquad section port checker
// Watches the top level ports: busy after an input beat, a stalled result
// holds, and a clipped result sits at a full-scale value.
// ----------------------------------------------------------------------------
`include "biquad_iir_section_top_assert.svh"

module bqs_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input logic                          out_clipped
);

  localparam logic [SAMPLE_BITS-1:0] FS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] FS_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // One item at a time: busy right after an input beat
  `BQS_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)

  // A stalled result beat stays put
  `BQS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_out) && $stable(out_clipped))

  // Saturation lands on full scale
  `BQS_ASSERT_SAME(a_clip_full_scale, out_valid && out_clipped, out_sample_out == FS_MAX || out_sample_out == FS_MIN)

endmodule

bind biquad_iir_section_top bqs_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bqs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_clipped    (out_clipped)
);

>>> sim/biquad_iir_section_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad section checker
// Watches the input, output and register ports of the biquad section,
// predicts each filtered sample from the beats it sees and compares every
// output beat with the oldest predicted one. It reports a failure count and
// the number of predicted samples still due.
// ----------------------------------------------------------------------------
module biquad_iir_section_checker import bqs_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 20,
  parameter int STATE_BITS     = 40
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          out_clipped,
  input  logic                          cfg_wr_en,
  input  logic [REG_IDX_BITS-1:0]       cfg_index,
  input  logic [COEF_BITS-1:0]          cfg_wdata,
  output int                            fail_count,
  output int                            pending_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          clipped;
  } filt_beat_t;

  // Filtered samples predicted but not yet seen on the output
  filt_beat_t filtered_q[$];

  // Shadow copy of the registers and the two delay values
  bit     bypass_r;
  longint coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  longint delay_one, delay_two;
  int     fails;

  // Coefficient times sample, rounded half up to the sample grid
  function automatic longint round_mul(input longint coef, input longint val);
    longint p;
    p = coef * val + (longint'(1) << (COEF_FRAC_BITS - 1));
    return p >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp_signed(input longint v, input int w, output bit hit);
    longint hi;
    longint lo;
    hi  = (longint'(1) << (w - 1)) - 1;
    lo  = -hi - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // One sample through the section; advances the delay values when filtering
  function automatic filt_beat_t biquad_step(input longint x);
    filt_beat_t r;
    longint     y;
    longint     n1;
    longint     n2;
    bit         clip;
    bit         unused_hit;
    if (bypass_r) begin
      r.sample  = x[SAMPLE_BITS-1:0];
      r.clipped = 1'b0;
      return r;
    end
    y  = clamp_signed(round_mul(coef_b0, x) + delay_one, SAMPLE_BITS, clip);
    // feedback takes the saturated output
    n1 = round_mul(coef_b1, x) - round_mul(coef_a1, y) + delay_two;
    n2 = round_mul(coef_b2, x) - round_mul(coef_a2, y);
    delay_one = clamp_signed(n1, STATE_BITS, unused_hit);
    delay_two = clamp_signed(n2, STATE_BITS, unused_hit);
    r.sample  = y[SAMPLE_BITS-1:0];
    r.clipped = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    filt_beat_t want;
    if (!rst_n) begin
      bypass_r  = 1'b1;
      coef_b0   = longint'(1) << COEF_FRAC_BITS;
      coef_b1   = 0;
      coef_b2   = 0;
      coef_a1   = 0;
      coef_a2   = 0;
      delay_one = 0;
      delay_two = 0;
      fails     = 0;
      filtered_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      // Compare an output beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          if (fails < REPORT_LIMIT)
            $display("%0t: output beat with none due: sample %0d clipped %0b",
                     $realtime, out_sample_out, out_clipped);
          fails++;
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_out !== want.sample || out_clipped !== want.clipped) begin
            if (fails < REPORT_LIMIT)
              $display("%0t: output mismatch: sample %0d (want %0d) clipped %0b (want %0b)",
                       $realtime, out_sample_out, want.sample, out_clipped, want.clipped);
            fails++;
          end
        end
      end

      // Track register writes; unused indexes are ignored
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BYPASS: bypass_r = cfg_wdata[0];
          REG_B0:     coef_b0 = longint'($signed(cfg_wdata));
          REG_B1:     coef_b1 = longint'($signed(cfg_wdata));
          REG_B2:     coef_b2 = longint'($signed(cfg_wdata));
          REG_A1:     coef_a1 = longint'($signed(cfg_wdata));
          REG_A2:     coef_a2 = longint'($signed(cfg_wdata));
          default: ;
        endcase
      end

      // Predict the result of an input beat
      if (in_valid && !in_stall)
        filtered_q.push_back(biquad_step(longint'(in_sample_in)));

      fail_count    <= fails;
      pending_count <= filtered_q.size();
    end
  end

endmodule

>>> sim/biquad_iir_section_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Biquad section testbench
// Drives samples and register settings into the biquad section with random
// gaps on the input and random stalls on the output. A directed opening
// covers sample and coefficient extremes, saturation, bypass over live state
// and rounding at the half step; random filter phases follow. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module biquad_iir_section_top_tb;
  import bqs_pkg::*;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int STATE_BITS     = 40;

  localparam int RANDOM_ITEMS   = 1430;
  localparam int CALM_ITEMS     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int NUM_INDEXES    = 1 << REG_IDX_BITS;

  localparam logic [COEF_BITS-1:0] COEF_ONE       = COEF_BITS'(1 << COEF_FRAC_BITS);
  localparam logic [COEF_BITS-1:0] COEF_MINUS_ONE = COEF_BITS'(-(1 << COEF_FRAC_BITS));
  localparam logic [COEF_BITS-1:0] COEF_MAX       = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0] COEF_MIN       = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN   = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_HALF  = SAMPLE_BITS'(1 << (COEF_FRAC_BITS - 1));

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_in;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          out_clipped;
  logic                          cfg_wr_en;
  logic [REG_IDX_BITS-1:0]       cfg_index;
  logic [COEF_BITS-1:0]          cfg_wdata;

  int fail_count;
  int pending_count;
  int quiet_cycles = 0;
  int stall_left   = 0;
  int gap_rate     = 0;   // 0: no input gaps, else one beat in gap_rate
  int stall_rate   = 0;   // 0: no output stalls, else one cycle in stall_rate

  logic [COEF_BITS-1:0] reg_val [NUM_INDEXES];

  biquad_iir_section_top #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STATE_BITS    (STATE_BITS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  biquad_iir_section_checker #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS),
    .STATE_BITS    (STATE_BITS)
  ) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_clipped   (out_clipped),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the output in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run when no beat or write moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one sample, maybe after a gap, and hold it until accepted
  task automatic drive_sample(input logic [SAMPLE_BITS-1:0] x);
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and wait for every predicted sample to come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drain, then write every index, the unused ones with random data
  task automatic load_filter(input bit byp, input logic [COEF_BITS-1:0] b0,
                             input logic [COEF_BITS-1:0] b1, input logic [COEF_BITS-1:0] b2,
                             input logic [COEF_BITS-1:0] a1, input logic [COEF_BITS-1:0] a2);
    for (int i = 0; i < NUM_INDEXES; i++)
      reg_val[i] = COEF_BITS'($urandom());
    reg_val[REG_BYPASS] = {reg_val[REG_BYPASS][COEF_BITS-1:1], byp};
    reg_val[REG_B0] = b0;
    reg_val[REG_B1] = b1;
    reg_val[REG_B2] = b2;
    reg_val[REG_A1] = a1;
    reg_val[REG_A2] = a2;
    drain();
    for (int i = 0; i < NUM_INDEXES; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= REG_IDX_BITS'(i);
      cfg_wdata <= reg_val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // kind 0: any bits, 1: within +-1.0, 2: extremes, zero and +-1.0
  function automatic logic [COEF_BITS-1:0] rand_coef(input int kind);
    int v;
    case (kind)
      1: begin
        v = int'($urandom_range(0, 2 << COEF_FRAC_BITS)) - (1 << COEF_FRAC_BITS);
        return v[COEF_BITS-1:0];
      end
      2: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return COEF_ONE;
          default: return COEF_MINUS_ONE;
        endcase
      end
      default: return COEF_BITS'($urandom());
    endcase
  endfunction

  // Mostly full range, some quiet signal, a few extremes
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 6)
      return SAMPLE_BITS'($urandom());
    if (r < 9) begin
      v = int'($urandom_range(0, 8191)) - 4096;
      return v[SAMPLE_BITS-1:0];
    end
    case ($urandom_range(0, 2))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      default: return '0;
    endcase
  endfunction

  initial begin
    int items;
    int phase_len;
    int kind;
    logic [COEF_BITS-1:0] c [5];
    in_valid     <= 1'b0;
    in_sample_in <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    rst_n        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings pass samples through
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drive_sample('0);

    // Unity gain over the sample extremes
    load_filter(1'b0, COEF_ONE, '0, '0, '0, '0);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drive_sample(SAMPLE_BITS'(1));
    drive_sample('1);
    drive_sample('0);

    // Largest gain: clip both ways
    load_filter(1'b0, COEF_MAX, '0, '0, '0, '0);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);

    // Extreme coefficients everywhere, alternating full scale input
    load_filter(1'b0, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);
    drive_sample(SAMPLE_MAX);
    drive_sample(SAMPLE_MIN);

    // Bypass over live state, then resume filtering from that state
    load_filter(1'b1, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    drive_sample(rand_sample());
    drive_sample(rand_sample());
    load_filter(1'b0, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    drive_sample(rand_sample());
    drive_sample(rand_sample());

    // Smallest gain: rounding exactly at and just below the half step
    load_filter(1'b0, COEF_BITS'(1), '0, '0, '0, '0);
    drive_sample(SAMPLE_HALF);
    drive_sample(-SAMPLE_HALF);
    drive_sample(SAMPLE_BITS'(-SAMPLE_HALF - 1));

    // Random filter phases; the last stretch runs without idling
    items = 0;
    while (items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 3);
      foreach (c[i]) c[i] = rand_coef(kind == 3 ? 0 : kind);
      if (items >= RANDOM_ITEMS - CALM_ITEMS) begin
        gap_rate   = 0;
        stall_rate = 0;
      end else begin
        gap_rate   = $urandom_range(0, 3) * 3;
        stall_rate = $urandom_range(0, 3) * 3;
      end
      load_filter(kind == 3, c[0], c[1], c[2], c[3], c[4]);
      phase_len = $urandom_range(40, 120);
      // Stop exactly at the planned item count
      if (phase_len > RANDOM_ITEMS - items)
        phase_len = RANDOM_ITEMS - items;
      repeat (phase_len) drive_sample(rand_sample());
      items += phase_len;
    end

    drain();
    if (fail_count == 0 && pending_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
